>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the checksum engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge of clk_i outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds on a rising edge of clk_i outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/core/icce_pkg.sv
// Types, register indexes, mode codes and the CRC byte step of the checksum engine.
`default_nettype none
package icce_pkg;

  // Configuration register indexes
  localparam logic CFG_CHECK_MODE  = 1'b0;
  localparam logic CFG_SKIP_OFFSET = 1'b1;

  localparam int unsigned SKIP_BITS = 20;
  localparam int unsigned CFG_BITS  = 20;

  // Check modes
  typedef logic [1:0] check_mode_t;
  localparam check_mode_t MODE_CRC16  = 2'd0;
  localparam check_mode_t MODE_WORD   = 2'd1;
  localparam check_mode_t MODE_BYTE   = 2'd2;
  localparam check_mode_t MODE_UNUSED = 2'd3;

  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  PAD_HIGH     = 8'hFF;
  localparam logic [SKIP_BITS-1:0] SKIP_RESET = '1;

  // One reflected CRC-16 byte update
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = {8'h00, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return (crc >> 8) ^ c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/image_crc16_checksum_engine_unit.sv
// Top level of the image checksum engine: CRC-16, word checksum or byte checksum per region.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------
//  in      | request   | in_valid_i/in_ready_o  | data_byte_i, last_byte_i
//  out     | result    | out_valid_o/out_ready_i| check_value_o
//  cfg     | write     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// One byte is taken per cycle while in_ready_o is high; the running value is updated
// on the accepting edge, and the result of a last byte is written into the result
// queue on that edge. The CRC step and the word add are combinational between the
// input port and the state and result registers. A two-entry result queue holds
// finished values; in_ready_o falls only while both entries are full.
// Reset is asynchronous and clears position, sums and queue at once; no sweep.
`default_nettype none
`include "assert_macros.svh"
module image_crc16_checksum_engine_unit #(
  parameter int unsigned POSITION_BITS = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [icce_pkg::CFG_BITS-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          last_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [31:0]                        check_value_o
);
  import icce_pkg::*;

  localparam int unsigned CMP_BITS =
    ((POSITION_BITS > SKIP_BITS) ? POSITION_BITS : SKIP_BITS) + 1;

  // Configuration and running state
  check_mode_t              mode_q;
  logic [SKIP_BITS-1:0]     skip_q;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [31:0]              acc_q, acc_d;
  logic [7:0]               cnt_q, cnt_d;
  logic [7:0]               low_q, low_d;

  // Result queue
  logic        out_valid_q, skid_valid_q;
  logic [31:0] out_data_q, skid_data_q;
  logic [31:0] result_d;

  logic in_fire, push, pop;
  logic [CMP_BITS-1:0] pos_ext, skip_ext, start_ext;
  logic                skip_crc, skip_byte, skip_word;
  logic [15:0]         word;
  logic [POSITION_BITS-1:0] start_pos;

  assign in_ready_o    = !skid_valid_q;
  assign in_fire       = in_valid_i && in_ready_o;
  assign push          = in_fire && last_byte_i;
  assign pop           = out_valid_q && out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign check_value_o = out_data_q;

  // Skip windows, compared without wrap
  assign start_pos = {pos_q[POSITION_BITS-1:1], 1'b0};
  assign pos_ext   = CMP_BITS'(pos_q);
  assign start_ext = CMP_BITS'(start_pos);
  assign skip_ext  = CMP_BITS'(skip_q);
  assign skip_byte = (pos_ext == skip_ext) || (pos_ext == skip_ext + CMP_BITS'(1));
  assign skip_crc  = skip_byte || (pos_ext == skip_ext + CMP_BITS'(2))
                               || (pos_ext == skip_ext + CMP_BITS'(3));
  assign skip_word = (start_ext == skip_ext) || (start_ext == skip_ext + CMP_BITS'(2));

  // Word for mode 1: odd position closes the pending word, even last byte pads it
  assign word = pos_q[0] ? {data_byte_i, low_q} : {PAD_HIGH, data_byte_i};

  // Update the running value for one byte
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    low_d = low_q;
    case (mode_q)
      MODE_CRC16: begin
        if (!skip_crc) acc_d = {16'h0000, crc16_byte(acc_q[15:0], data_byte_i)};
      end
      MODE_WORD: begin
        if (!pos_q[0]) low_d = data_byte_i;
        if ((pos_q[0] || last_byte_i) && !skip_word) begin
          acc_d = acc_q + {16'h0000, word} + {24'h000000, cnt_q};
          cnt_d = cnt_q + 8'd1;
        end
      end
      MODE_BYTE: begin
        if (!skip_byte) acc_d = {16'h0000, acc_q[15:0] + {8'h00, data_byte_i}};
      end
      default: ;
    endcase
    case (mode_q)
      MODE_WORD:   result_d = acc_d;
      MODE_UNUSED: result_d = '0;
      default:     result_d = {16'h0000, acc_d[15:0]};
    endcase
    pos_d = pos_q + POSITION_BITS'(1);
  end

  // Hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CRC16;
      skip_q <= SKIP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CHECK_MODE:  mode_q <= cfg_data_i[1:0];
        CFG_SKIP_OFFSET: skip_q <= cfg_data_i[SKIP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Advance the running state, clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      acc_q <= '0;
      cnt_q <= '0;
      low_q <= '0;
    end else if (in_fire) begin
      if (last_byte_i) begin
        pos_q <= '0;
        acc_q <= '0;
        cnt_q <= '0;
        low_q <= '0;
      end else begin
        pos_q <= pos_d;
        acc_q <= acc_d;
        cnt_q <= cnt_d;
        low_q <= low_d;
      end
    end
  end

  // Queue results: output entry first, skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      if (!out_valid_q) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Payload of the queue
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (push) begin
        out_data_q <= result_d;
      end
    end else if (push) begin
      if (!out_valid_q) begin
        out_data_q <= result_d;
      end else begin
        skid_data_q <= result_d;
      end
    end
  end

  `ASSERT_CLK(a_skid_behind_out, skid_valid_q |-> out_valid_q,
              "skid entry valid while output entry empty")
  `ASSERT_CLK(a_skid_kept, (skid_valid_q && !pop) |=> skid_valid_q,
              "queued result lost without a pop")
  `ASSERT_CLK(a_pos_cleared, push |=> (pos_q == '0 && acc_q == '0 && cnt_q == '0),
              "state not cleared after last byte")
  `ASSERT_NEVER(a_upper_zero, push && (mode_q != MODE_WORD) && (result_d[31:16] != 16'h0000),
                "upper bits set in a 16-bit mode")

endmodule
`default_nettype wire
